// File: src/iavt_pkg.sv
`default_nettype none

package iavt_pkg;

  // Coordinate format of vertices, results and the stored inverse.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Frame entries are signed Q5.16, three to a register.
  localparam int ENTRY_BITS  = 21;
  localparam int ENTRY_FRAC  = 16;
  localparam int REG_BITS    = 3 * ENTRY_BITS;
  localparam int NUM_REGS    = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN    = CFG_IDX_W'(NUM_REGS - 1);

  // Setup arithmetic.
  localparam int SETUP_SHIFT = ENTRY_FRAC + FRAC_BITS;
  localparam int ADJ_W       = 2 * ENTRY_BITS + 1;
  localparam int ADJ_SPLIT   = ENTRY_BITS + 1;
  localparam int MUL_A_W     = ENTRY_BITS;
  localparam int MUL_B_W     = ADJ_SPLIT + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int DET_W       = 64;
  localparam int NUM_W       = ADJ_W + 1 + SETUP_SHIFT;
  localparam int DIV_STEPS   = NUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int NUM_OPS     = 24;
  localparam int OP_W        = $clog2(NUM_OPS);
  localparam int MAT_N       = 9;
  localparam int MAT_IDX_W   = 4;

  // Origin alignment and vertex datapath widths.
  localparam int ALIGN_UP = (FRAC_BITS >= ENTRY_FRAC) ? FRAC_BITS - ENTRY_FRAC : 0;
  localparam int ALIGN_DN = (FRAC_BITS >= ENTRY_FRAC) ? 0 : ENTRY_FRAC - FRAC_BITS;
  localparam int ORG_W    = ENTRY_BITS + ALIGN_UP;
  localparam int DIFF_W   = ((COORD_WIDTH > ORG_W) ? COORD_WIDTH : ORG_W) + 1;
  localparam int PMUL_W   = DIFF_W + COORD_WIDTH;
  localparam int SUM_W    = PMUL_W + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = Q_PTR_W + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t [MAT_N-1:0] inv_mat_t;
  typedef logic signed [ORG_W-1:0] org_t;
  typedef org_t [2:0] org_vec_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;
    logic                          last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] local_x;
    logic signed [COORD_WIDTH-1:0] local_y;
    logic signed [COORD_WIDTH-1:0] local_z;
    logic                          singular;
    logic                          mesh_end;
  } out_item_t;

  typedef struct packed {
    diff_t [2:0] d;
    logic        last;
  } work_item_t;

  typedef struct packed {
    logic busy;
    logic singular;
  } setup_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_DONE
  } setup_state_t;

  typedef enum logic [1:0] {
    SRC_M,
    SRC_ADJ_LO,
    SRC_ADJ_HI
  } b_src_t;

  typedef struct packed {
    logic [MAT_IDX_W-1:0] a_idx;
    logic [MAT_IDX_W-1:0] b_idx;
    b_src_t               b_src;
    logic                 sub;
    logic                 first;
    logic [MAT_IDX_W-1:0] dest;
  } uop_t;

  localparam logic [MAT_IDX_W-1:0] DEST_DET = MAT_IDX_W'(MAT_N);

  function automatic uop_t mk_uop(input int a, input int b, input b_src_t s,
                                  input logic sub, input logic first, input int dest);
    uop_t u;
    u.a_idx = MAT_IDX_W'(a);
    u.b_idx = MAT_IDX_W'(b);
    u.b_src = s;
    u.sub   = sub;
    u.first = first;
    u.dest  = MAT_IDX_W'(dest);
    return u;
  endfunction

  // Sequence of multiply-accumulate steps for the adjugate and determinant.
  // The determinant products multiply a 21-bit entry by a 43-bit cofactor,
  // so each is split into a low unsigned half and a high signed half.
  function automatic uop_t uop_rom(input logic [OP_W-1:0] op);
    uop_t u;
    unique case (op)
      5'd0:  u = mk_uop(4, 8, SRC_M, 1'b0, 1'b1, 0);
      5'd1:  u = mk_uop(5, 7, SRC_M, 1'b1, 1'b0, 0);
      5'd2:  u = mk_uop(2, 7, SRC_M, 1'b0, 1'b1, 1);
      5'd3:  u = mk_uop(1, 8, SRC_M, 1'b1, 1'b0, 1);
      5'd4:  u = mk_uop(1, 5, SRC_M, 1'b0, 1'b1, 2);
      5'd5:  u = mk_uop(2, 4, SRC_M, 1'b1, 1'b0, 2);
      5'd6:  u = mk_uop(5, 6, SRC_M, 1'b0, 1'b1, 3);
      5'd7:  u = mk_uop(3, 8, SRC_M, 1'b1, 1'b0, 3);
      5'd8:  u = mk_uop(0, 8, SRC_M, 1'b0, 1'b1, 4);
      5'd9:  u = mk_uop(2, 6, SRC_M, 1'b1, 1'b0, 4);
      5'd10: u = mk_uop(2, 3, SRC_M, 1'b0, 1'b1, 5);
      5'd11: u = mk_uop(0, 5, SRC_M, 1'b1, 1'b0, 5);
      5'd12: u = mk_uop(3, 7, SRC_M, 1'b0, 1'b1, 6);
      5'd13: u = mk_uop(4, 6, SRC_M, 1'b1, 1'b0, 6);
      5'd14: u = mk_uop(1, 6, SRC_M, 1'b0, 1'b1, 7);
      5'd15: u = mk_uop(0, 7, SRC_M, 1'b1, 1'b0, 7);
      5'd16: u = mk_uop(0, 4, SRC_M, 1'b0, 1'b1, 8);
      5'd17: u = mk_uop(1, 3, SRC_M, 1'b1, 1'b0, 8);
      5'd18: u = mk_uop(0, 0, SRC_ADJ_LO, 1'b0, 1'b1, MAT_N);
      5'd19: u = mk_uop(0, 0, SRC_ADJ_HI, 1'b0, 1'b0, MAT_N);
      5'd20: u = mk_uop(1, 3, SRC_ADJ_LO, 1'b0, 1'b0, MAT_N);
      5'd21: u = mk_uop(1, 3, SRC_ADJ_HI, 1'b0, 1'b0, MAT_N);
      5'd22: u = mk_uop(2, 6, SRC_ADJ_LO, 1'b0, 1'b0, MAT_N);
      5'd23: u = mk_uop(2, 6, SRC_ADJ_HI, 1'b0, 1'b0, MAT_N);
      default: u = mk_uop(0, 0, SRC_M, 1'b0, 1'b1, MAT_N);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: src/iavt_setup.sv
`default_nettype none

module iavt_setup import iavt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_BITS-1:0]  cfg_wdata,
  output inv_mat_t             inv_mat,
  output org_vec_t             origin,
  output setup_status_t        status
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [OP_W-1:0]      OP_LAST  = OP_W'(NUM_OPS - 1);
  localparam logic [MAT_IDX_W-1:0] ENT_LAST = MAT_IDX_W'(MAT_N - 1);
  localparam logic [COORD_WIDTH:0] Q_CAP    = (COORD_WIDTH + 1)'(1) << COORD_WIDTH;
  localparam logic [COORD_WIDTH:0] Q_LIM    = (COORD_WIDTH + 1)'(1) << (COORD_WIDTH - 1);
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
  localparam coord_t COORD_ONE = coord_t'(1) << FRAC_BITS;

  setup_state_t state_r, state_nxt;
  logic [REG_BITS-1:0]  frame_r [NUM_REGS];
  logic [OP_W-1:0]      op_r;
  logic [MAT_IDX_W-1:0] ent_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  coord_t               inv_r [MAT_N];
  logic                 sing_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [DET_W-1:0]  acc_r;
  logic signed [ADJ_W-1:0]  adj_r [MAT_N];
  logic signed [DET_W-1:0]  det_r;
  logic [NUM_W-1:0]         num_r;
  logic [DET_W-1:0]         rem_r;
  logic [DET_W-1:0]         dvs_r;
  logic [COORD_WIDTH:0]     q_r;
  logic                     sat_r;
  logic                     neg_r;

  logic cfg_hit;
  logic mul_en, acc_en, div_load, div_step, div_done;
  uop_t uop;
  logic signed [ENTRY_BITS-1:0] m [MAT_N];
  logic [MAT_IDX_W-1:0]     rd_idx;
  logic signed [ADJ_W-1:0]  adj_rd;
  logic signed [MUL_A_W-1:0] a_op;
  logic signed [MUL_B_W-1:0] b_op;
  logic signed [DET_W-1:0]  prod_ext, prod_sh, acc_nxt;
  logic [DET_W:0]           rs;
  logic                     ge;
  logic [COORD_WIDTH:0]     qs, qf;
  logic                     rnd;
  coord_t                   inv_nxt;
  logic [ADJ_W:0]           n_abs;

  assign cfg_hit = cfg_we && (cfg_idx <= REG_ORIGIN);
  assign uop     = uop_rom(op_r);

  always_comb begin
    for (int i = 0; i < MAT_N; i++) begin
      m[i] = frame_r[i / 3][(i % 3) * ENTRY_BITS +: ENTRY_BITS];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      origin[k] = (ORG_W'($signed(frame_r[NUM_REGS - 1][k * ENTRY_BITS +: ENTRY_BITS]))
                   <<< ALIGN_UP) >>> ALIGN_DN;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     state_nxt = ST_IDLE;
      ST_MUL:      state_nxt = ST_ACC;
      ST_ACC:      state_nxt = (op_r == OP_LAST) ? ST_DIV_LOAD : ST_MUL;
      ST_DIV_LOAD: state_nxt = (det_r == '0) ? ST_IDLE : ST_DIV_STEP;
      ST_DIV_STEP: state_nxt = (cnt_r == CNT_LAST) ? ST_DIV_DONE : ST_DIV_STEP;
      ST_DIV_DONE: state_nxt = (ent_r == ENT_LAST) ? ST_IDLE : ST_DIV_LOAD;
      default:     state_nxt = ST_IDLE;
    endcase
    if (cfg_hit) begin
      state_nxt = ST_MUL;
    end
  end

  // State outputs.
  always_comb begin
    mul_en   = 1'b0;
    acc_en   = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    div_done = 1'b0;
    unique case (state_r)
      ST_IDLE:     mul_en   = 1'b0;
      ST_MUL:      mul_en   = 1'b1;
      ST_ACC:      acc_en   = 1'b1;
      ST_DIV_LOAD: div_load = 1'b1;
      ST_DIV_STEP: div_step = 1'b1;
      ST_DIV_DONE: div_done = 1'b1;
      default:     mul_en   = 1'b0;
    endcase
  end

  // Shared multiplier operands; the cofactor store has a single read port.
  assign rd_idx = div_load ? ent_r : uop.b_idx;
  assign adj_rd = adj_r[rd_idx];
  assign a_op   = m[uop.a_idx];

  always_comb begin
    unique case (uop.b_src)
      SRC_M:      b_op = MUL_B_W'(m[uop.b_idx]);
      SRC_ADJ_LO: b_op = $signed({1'b0, adj_rd[ADJ_SPLIT-1:0]});
      SRC_ADJ_HI: b_op = MUL_B_W'($signed(adj_rd[ADJ_W-1:ADJ_SPLIT]));
      default:    b_op = '0;
    endcase
  end

  assign prod_ext = DET_W'(prod_r);
  assign prod_sh  = (uop.b_src == SRC_ADJ_HI) ? (prod_ext <<< ADJ_SPLIT) : prod_ext;
  assign acc_nxt  = (uop.first ? '0 : acc_r) + (uop.sub ? -prod_sh : prod_sh);

  // One restoring division step per cycle.
  assign rs = {rem_r, num_r[NUM_W-1]};
  assign ge = rs >= {1'b0, dvs_r};
  assign qs = {q_r[COORD_WIDTH-1:0], ge};

  assign rnd = !sat_r && (rem_r >= (dvs_r - rem_r));
  assign qf  = q_r + (COORD_WIDTH + 1)'(rnd);

  always_comb begin
    if (!neg_r) begin
      inv_nxt = (qf >= Q_LIM) ? COORD_MAX : coord_t'(qf[COORD_WIDTH-1:0]);
    end else begin
      inv_nxt = (qf >= Q_LIM) ? COORD_MIN : coord_t'(-qf[COORD_WIDTH-1:0]);
    end
  end

  assign n_abs = adj_rd[ADJ_W-1] ? (ADJ_W + 1)'(-adj_rd) : (ADJ_W + 1)'(adj_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      frame_r[0] <= REG_BITS'(1) << ENTRY_FRAC;
      frame_r[1] <= REG_BITS'(1) << (ENTRY_FRAC + ENTRY_BITS);
      frame_r[2] <= REG_BITS'(1) << (ENTRY_FRAC + 2 * ENTRY_BITS);
      frame_r[3] <= '0;
      op_r       <= '0;
      ent_r      <= '0;
      cnt_r      <= '0;
      sing_r     <= 1'b0;
      for (int i = 0; i < MAT_N; i++) begin
        inv_r[i] <= ((i % 4) == 0) ? COORD_ONE : '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        frame_r[cfg_idx[1:0]] <= cfg_wdata;
        op_r                  <= '0;
      end else if (acc_en) begin
        op_r <= op_r + OP_W'(1);
        if (op_r == OP_LAST) begin
          ent_r <= '0;
        end
      end
      if (div_load) begin
        cnt_r <= '0;
        if (det_r == '0) begin
          sing_r <= 1'b1;
          for (int i = 0; i < MAT_N; i++) begin
            inv_r[i] <= '0;
          end
        end else begin
          sing_r <= 1'b0;
        end
      end
      if (div_step) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      if (div_done) begin
        inv_r[ent_r] <= inv_nxt;
        ent_r        <= ent_r + MAT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= a_op * b_op;
    end
    if (acc_en) begin
      acc_r <= acc_nxt;
      if (uop.dest == DEST_DET) begin
        det_r <= acc_nxt;
      end else begin
        adj_r[uop.dest] <= acc_nxt[ADJ_W-1:0];
      end
    end
    if (div_load) begin
      num_r <= {n_abs, {SETUP_SHIFT{1'b0}}};
      rem_r <= '0;
      dvs_r <= det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
      q_r   <= '0;
      sat_r <= 1'b0;
      neg_r <= adj_rd[ADJ_W-1] ^ det_r[DET_W-1];
    end
    if (div_step) begin
      num_r <= num_r << 1;
      rem_r <= ge ? DET_W'(rs - {1'b0, dvs_r}) : DET_W'(rs);
      if (!sat_r) begin
        if (qs >= Q_CAP) begin
          q_r   <= Q_CAP;
          sat_r <= 1'b1;
        end else begin
          q_r <= qs;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAT_N; i++) begin
      inv_mat[i] = inv_r[i];
    end
  end

  assign status.busy     = (state_r != ST_IDLE);
  assign status.singular = sing_r;

endmodule

`default_nettype wire

// File: src/iavt_front.sv
`default_nettype none

module iavt_front import iavt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  input  org_vec_t      origin,
  input  setup_status_t status,
  input  logic          pop,
  output logic          q_valid,
  output work_item_t    q_head
);

  work_item_t           q_mem_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 push;
  work_item_t           item;

  // Translation is removed at the door; the difference is kept exact.
  always_comb begin
    item.d[0] = DIFF_W'($signed(in_data.vertex_x)) - DIFF_W'($signed(origin[0]));
    item.d[1] = DIFF_W'($signed(in_data.vertex_y)) - DIFF_W'($signed(origin[1]));
    item.d[2] = DIFF_W'($signed(in_data.vertex_z)) - DIFF_W'($signed(origin[2]));
    item.last = in_data.last_vertex;
  end

  assign in_ready = !status.busy && (cnt_r != Q_CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_mem_r[rd_ptr_r];
  assign cnt_nxt  = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// File: src/iavt_back.sv
`default_nettype none

module iavt_back import iavt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  work_item_t    q_head,
  output logic          pop,
  input  inv_mat_t      inv_mat,
  input  setup_status_t status,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI   = (SUM_W'(1) <<< (COORD_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO   = -(SUM_W'(1) <<< (COORD_WIDTH - 1));
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic signed [PMUL_W-1:0] prod_r [3][3];
  logic                     s1_vld_r, s1_last_r;
  logic signed [SUM_W-1:0]  sum_r [3];
  logic                     s2_vld_r, s2_last_r;
  out_item_t                out_r;
  logic                     out_vld_r;
  logic                     adv;

  function automatic coord_t round_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    r = (s + RND_HALF) >>> FRAC_BITS;
    if (r > SAT_HI) begin
      return COORD_MAX;
    end else if (r < SAT_LO) begin
      return COORD_MIN;
    end
    return coord_t'(r[COORD_WIDTH-1:0]);
  endfunction

  // The whole pipe moves together whenever the output register can take data.
  assign adv = !out_vld_r || out_ready;
  assign pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= q_valid;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[j][k] <= $signed(q_head.d[k]) * $signed(inv_mat[k * 3 + j]);
        end
        sum_r[j] <= SUM_W'(prod_r[j][0]) + SUM_W'(prod_r[j][1]) + SUM_W'(prod_r[j][2]);
      end
      s1_last_r <= q_head.last;
      s2_last_r <= s1_last_r;
      out_r.singular <= status.singular;
      out_r.mesh_end <= s2_last_r;
      if (status.singular) begin
        out_r.local_x <= '0;
        out_r.local_y <= '0;
        out_r.local_z <= '0;
      end else begin
        out_r.local_x <= round_sat(sum_r[0]);
        out_r.local_y <= round_sat(sum_r[1]);
        out_r.local_z <= round_sat(sum_r[2]);
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: src/inverse_affine_vertex_transform.sv
// A vertex passes the front queue, then the product, sum and output registers.
// Throughput: one vertex per clock while the frame is stable and out_ready is
// high; the nine multipliers of the back pipe are replicated so nothing in the
// vertex path is shared. A frame register write starts setup: cofactors and the
// determinant, then, unless it is zero, each inverse entry on the bit-serial divider.
// Reset (rst_n low, synchronous) loads the identity frame and identity inverse.
`default_nettype none

module inverse_affine_vertex_transform import iavt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_BITS-1:0]  cfg_data
);

  inv_mat_t      inv_mat;
  org_vec_t      origin;
  setup_status_t status;
  logic          q_valid;
  work_item_t    q_head;
  logic          pop;

  // Register writes are always taken. A write to an index past the frame
  // origin is dropped and does not restart setup.
  assign cfg_ready = 1'b1;

  // Setup sequencer: holds the frame registers, forms the cofactors and the
  // determinant on one shared multiplier, then, unless the determinant is zero,
  // divides each cofactor by it one quotient bit per cycle. While it runs, the
  // front stops accepting vertex transactions.
  iavt_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .inv_mat   (inv_mat),
    .origin    (origin),
    .status    (status)
  );

  // Front: accepts vertex transactions, removes the translation and parks the
  // differences in a short queue, so the input side keeps flowing while the
  // output side stalls, until the queue fills.
  iavt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .origin   (origin),
    .status   (status),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_head   (q_head)
  );

  // Back: products, sum, rounding with saturation (zeros for a singular frame), and the output register.
  iavt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .inv_mat   (inv_mat),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // A frame write closes the input; this checks that in_ready is low right after the write.
  a_cfg_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index <= REG_ORIGIN)) |=> !in_ready)
    else $error("vertex input open right after a frame write");

  // A singular frame yields zero coordinates.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |->
      (out_data.local_x == '0 && out_data.local_y == '0 && out_data.local_z == '0))
    else $error("nonzero coordinates with a singular frame");

  // Setup only starts because of a register write.
  a_setup_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.busy) |-> $past(cfg_valid && cfg_ready))
    else $error("setup started without a register write");
`endif

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
  import iavt_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_BITS-1:0]  cfg_data;

  inverse_affine_vertex_transform u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the frame registers and of the inverse that the block
  // should hold after its setup pass.
  logic [REG_BITS-1:0]          frame_shadow [NUM_REGS];
  logic signed [COORD_WIDTH-1:0] inverse_shadow [MAT_N];
  logic                          singular_shadow;

  in_item_t  vertex_q [$];   // vertices waiting to be driven
  out_item_t local_q  [$];   // predicted results, oldest first

  int mismatches;
  int idle_cycles;
  int gap_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sign-extend one 21-bit frame entry.
  function automatic logic signed [63:0] frame_entry(int r, int k);
    logic signed [ENTRY_BITS-1:0] e;
    e = frame_shadow[r][k*ENTRY_BITS +: ENTRY_BITS];
    return e;
  endfunction

  // Cofactor divided by the determinant, scaled to the inverse format, rounded
  // half away from zero and saturated. The quotient saturates once it no longer
  // fits the coordinate width, and then it is not rounded.
  function automatic logic signed [COORD_WIDTH-1:0] scaled_quotient(
      logic signed [127:0] num, logic signed [127:0] den);
    logic         neg;
    logic [127:0] un, ud, q, r;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un << SETUP_SHIFT) / ud;
    r = (un << SETUP_SHIFT) % ud;
    if (q < (128'd1 << COORD_WIDTH) && (r << 1) >= ud) q = q + 1;
    if (!neg) begin
      if (q >= (128'd1 << (COORD_WIDTH - 1))) return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      return q[COORD_WIDTH-1:0];
    end
    if (q >= (128'd1 << (COORD_WIDTH - 1))) return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    return -q[COORD_WIDTH-1:0];
  endfunction

  // Recompute the inverse from the shadow frame, as the setup pass does.
  function automatic void rebuild_inverse();
    logic signed [127:0] m [MAT_N];
    logic signed [127:0] adj [MAT_N];
    logic signed [127:0] det;
    for (int i = 0; i < MAT_N; i++) m[i] = frame_entry(i / 3, i % 3);
    adj[0] = m[4] * m[8] - m[5] * m[7];
    adj[1] = m[2] * m[7] - m[1] * m[8];
    adj[2] = m[1] * m[5] - m[2] * m[4];
    adj[3] = m[5] * m[6] - m[3] * m[8];
    adj[4] = m[0] * m[8] - m[2] * m[6];
    adj[5] = m[2] * m[3] - m[0] * m[5];
    adj[6] = m[3] * m[7] - m[4] * m[6];
    adj[7] = m[1] * m[6] - m[0] * m[7];
    adj[8] = m[0] * m[4] - m[1] * m[3];
    det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
    singular_shadow = (det == 0);
    for (int i = 0; i < MAT_N; i++)
      inverse_shadow[i] = singular_shadow ? '0 : scaled_quotient(adj[i], det);
  endfunction

  // Expected local-frame coordinates of one world-space vertex.
  function automatic out_item_t local_of(in_item_t v);
    out_item_t           res;
    logic signed [127:0] delta [3];
    logic signed [127:0] acc;
    logic signed [COORD_WIDTH-1:0] c [3];
    logic signed [COORD_WIDTH-1:0] coord;
    c[0] = v.vertex_x;
    c[1] = v.vertex_y;
    c[2] = v.vertex_z;
    // FRAC_BITS equals the entry fraction here, so the origin needs no shift.
    for (int k = 0; k < 3; k++) delta[k] = c[k] - frame_entry(NUM_REGS - 1, k);
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc = acc + delta[k] * inverse_shadow[k*3 + j];
      acc = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (acc > 128'sd2147483647) coord = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      else if (acc < -128'sd2147483648) coord = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      else coord = acc[COORD_WIDTH-1:0];
      if (singular_shadow) coord = '0;
      if (j == 0) res.local_x = coord;
      else if (j == 1) res.local_y = coord;
      else res.local_z = coord;
    end
    res.singular = singular_shadow;
    res.mesh_end = v.last_vertex;
    return res;
  endfunction

  // Driver: presents queued vertices and predicts each one as it is accepted.
  // Each vertex may be followed by a random gap with in_valid low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) local_q.push_back(local_of(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (vertex_q.size() > 0) begin
          in_data  <= vertex_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction and
  // may stall the result channel at random after each one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (local_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        out_item_t want;
        want = local_q.pop_front();
        if (want !== out_data) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h s=%b e=%b, got x=%h y=%h z=%h s=%b e=%b",
                     want.local_x, want.local_y, want.local_z, want.singular, want.mesh_end,
                     out_data.local_x, out_data.local_y, out_data.local_z,
                     out_data.singular, out_data.mesh_end);
        end
      end
      stall_left <= $urandom_range(0, 3);
      out_ready  <= ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a long stretch with no transaction on any channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One register write transaction; the shadow frame follows it at the handshake.
  task automatic write_frame(logic [CFG_IDX_W-1:0] idx, logic [REG_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx < NUM_REGS) begin
      frame_shadow[idx] = value;
      rebuild_inverse();
    end
  endtask

  // Entry generator: full range, near unit scale, or an extreme.
  function automatic logic [ENTRY_BITS-1:0] pick_entry();
    case ($urandom_range(0, 5))
      0, 1:    return ENTRY_BITS'($urandom);
      2, 3, 4: return ENTRY_BITS'($urandom_range(0, 1 << 18) - (1 << 17));
      default: return $urandom_range(0, 1) ? {1'b0, {(ENTRY_BITS-1){1'b1}}}
                                           : {1'b1, {(ENTRY_BITS-1){1'b0}}};
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] pick_row();
    return {pick_entry(), pick_entry(), pick_entry()};
  endfunction

  function automatic logic [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2, 3:    return COORD_WIDTH'($urandom_range(0, 1 << 22) - (1 << 21));
      4:       return COORD_WIDTH'($urandom_range(0, 1 << 12) - (1 << 11));
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic in_item_t make_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic last);
    in_item_t v;
    v.vertex_x    = x;
    v.vertex_y    = y;
    v.vertex_z    = z;
    v.last_vertex = last;
    return v;
  endfunction

  // Wait until the sender is empty and every predicted result has arrived.
  task automatic drain();
    do @(posedge clk); while (vertex_q.size() != 0 || in_valid || local_q.size() != 0);
    repeat (5) @(posedge clk);
  endtask

  localparam logic [ENTRY_BITS-1:0] E_ONE = ENTRY_BITS'(1 << ENTRY_FRAC);
  localparam logic [ENTRY_BITS-1:0] E_MAX = {1'b0, {(ENTRY_BITS-1){1'b1}}};
  localparam logic [ENTRY_BITS-1:0] E_MIN = {1'b1, {(ENTRY_BITS-1){1'b0}}};
  localparam logic [ENTRY_BITS-1:0] E_LSB = ENTRY_BITS'(1);
  localparam logic [ENTRY_BITS-1:0] E_ZERO = '0;

  initial begin
    in_item_t v;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_ROW_ONE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    frame_shadow[REG_ROW_ONE]   = {E_ZERO, E_ZERO, E_ONE};
    frame_shadow[REG_ROW_TWO]   = {E_ZERO, E_ONE, E_ZERO};
    frame_shadow[REG_ROW_THREE] = {E_ONE, E_ZERO, E_ZERO};
    frame_shadow[REG_ORIGIN]    = '0;
    rebuild_inverse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed vertices against the reset frame: extremes, zero, small
    // negatives and the mesh end marker both ways.
    vertex_q.push_back(make_vertex(32'h0, 32'h0, 32'h0, 1'b0));
    vertex_q.push_back(make_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
    vertex_q.push_back(make_vertex(32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    vertex_q.push_back(make_vertex(32'h7fffffff, 32'h80000000, 32'h0, 1'b1));
    vertex_q.push_back(make_vertex(32'h00010000, 32'hffff0000, 32'h00008000, 1'b0));
    vertex_q.push_back(make_vertex(32'hffffffff, 32'h00000001, 32'hffff8000, 1'b0));
    drain();

    // Origin at the extremes with the identity rotation: for the first vertex
    // the difference leaves the coordinate range and the result saturates.
    write_frame(REG_ORIGIN, {E_MAX, E_MIN, E_MAX});
    vertex_q.push_back(make_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1));
    vertex_q.push_back(make_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0));
    vertex_q.push_back(make_vertex(32'h0, 32'h0, 32'h0, 1'b0));
    drain();

    // Rank-one frame, all entries at the maximum: the frame is singular.
    write_frame(REG_ROW_ONE, {E_MAX, E_MAX, E_MAX});
    write_frame(REG_ROW_TWO, {E_MAX, E_MAX, E_MAX});
    write_frame(REG_ROW_THREE, {E_MAX, E_MAX, E_MAX});
    vertex_q.push_back(make_vertex(32'h12345678, 32'h80000000, 32'h7fffffff, 1'b1));
    vertex_q.push_back(make_vertex(32'h0, 32'h0, 32'h0, 1'b0));
    drain();

    // Diagonal of one least significant bit: a tiny determinant, so the
    // diagonal inverse entries saturate.
    write_frame(REG_ROW_ONE, {E_ZERO, E_ZERO, E_LSB});
    write_frame(REG_ROW_TWO, {E_ZERO, E_LSB, E_ZERO});
    write_frame(REG_ROW_THREE, {E_LSB, E_ZERO, E_ZERO});
    write_frame(REG_ORIGIN, '0);
    vertex_q.push_back(make_vertex(32'h00000001, 32'hffffffff, 32'h0, 1'b0));
    vertex_q.push_back(make_vertex(32'h0, 32'h0, 32'h0, 1'b1));
    drain();

    // Diagonal at the most negative entry, origin at its minimum; then a
    // write to an index past the last register, which the block ignores.
    write_frame(REG_ROW_ONE, {E_ZERO, E_ZERO, E_MIN});
    write_frame(REG_ROW_TWO, {E_ZERO, E_MIN, E_ZERO});
    write_frame(REG_ROW_THREE, {E_MIN, E_ZERO, E_ZERO});
    write_frame(REG_ORIGIN, {E_MIN, E_MIN, E_MIN});
    write_frame(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 3)), pick_row());
    vertex_q.push_back(make_vertex(32'h7fffffff, 32'h00010000, 32'h80000000, 1'b0));
    vertex_q.push_back(make_vertex(32'h0, 32'h0, 32'h0, 1'b1));
    drain();

    // Random phases: a fresh frame each time, then a burst of vertices.
    // Each phase boundary holds the sender until every result is back.
    for (int phase = 0; phase < 12; phase++) begin
      write_frame(REG_ROW_ONE, pick_row());
      write_frame(REG_ROW_TWO, pick_row());
      write_frame(REG_ROW_THREE, pick_row());
      write_frame(REG_ORIGIN, (phase % 3 == 0) ? pick_row() : REG_BITS'(0));
      for (int n = 0; n < 136; n++) begin
        v = make_vertex(pick_coord(), pick_coord(), pick_coord(),
                        ($urandom_range(0, 7) == 0));
        vertex_q.push_back(v);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && local_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
src/iavt_pkg.sv
src/iavt_setup.sv
src/iavt_front.sv
src/iavt_back.sv
src/inverse_affine_vertex_transform.sv
test/testbench.sv
